// ===== hw/rtl/utf8_stream_validator_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 stream validator assertion macros
// Shared concurrent assertion forms used by the validator RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define U8SV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8sv assertion failed");

// Next-cycle implication, checked only while out of reset.
`define U8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8sv assertion failed");

`endif

// ===== hw/rtl/u8sv_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream validator package
// Transaction types, byte constants and continuation range classes.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic byte_ok;
        logic string_valid;
        logic end_of_string;
    } t_out_item;

    // Allowed range of the next continuation byte.
    typedef enum logic [2:0] {
        RC_PLAIN = 3'd0,  // 0x80-0xBF
        RC_E0    = 3'd1,  // 0xA0-0xBF
        RC_ED    = 3'd2,  // 0x80-0x9F
        RC_F0    = 3'd3,  // 0x90-0xBF
        RC_F4    = 3'd4   // 0x80-0x8F
    } t_range_class;

    localparam logic [7:0] BYTE_TAB        = 8'h09;
    localparam logic [7:0] BYTE_LF         = 8'h0A;
    localparam logic [7:0] BYTE_CR         = 8'h0D;
    localparam logic [7:0] BYTE_PRINT_LO   = 8'h20;
    localparam logic [7:0] BYTE_PRINT_HI   = 8'h7E;
    localparam logic [7:0] BYTE_LEAD2_LO   = 8'hC2;
    localparam logic [7:0] BYTE_LEAD2_HI   = 8'hDF;
    localparam logic [7:0] BYTE_LEAD_E0    = 8'hE0;
    localparam logic [7:0] BYTE_LEAD_ED    = 8'hED;
    localparam logic [7:0] BYTE_LEAD3_HI   = 8'hEF;
    localparam logic [7:0] BYTE_LEAD_F0    = 8'hF0;
    localparam logic [7:0] BYTE_LEAD_F4    = 8'hF4;
    localparam logic [7:0] BYTE_CONT_LO    = 8'h80;
    localparam logic [7:0] BYTE_CONT_8F    = 8'h8F;
    localparam logic [7:0] BYTE_CONT_90    = 8'h90;
    localparam logic [7:0] BYTE_CONT_9F    = 8'h9F;
    localparam logic [7:0] BYTE_CONT_A0    = 8'hA0;
    localparam logic [7:0] BYTE_CONT_HI    = 8'hBF;

endpackage

// ===== hw/rtl/u8sv_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validator step unit
// Holds the per-string decode state and judges one byte per enabled cycle.
// ----------------------------------------------------------------------------
`include "utf8_stream_validator_assert.svh"

module u8sv_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  u8sv_pkg::t_in_item  i_item,
    output u8sv_pkg::t_out_item o_item
);

    logic [1:0]             r_pending;
    logic [1:0]             n_pending;
    u8sv_pkg::t_range_class r_class;
    u8sv_pkg::t_range_class n_class;
    logic                   r_error;
    logic                   n_error;

    logic [7:0]             b;
    logic                   cont_ok;
    logic                   lead_ok;
    logic [1:0]             lead_cnt;
    u8sv_pkg::t_range_class lead_cls;
    logic                   ok;

    assign b = i_item.data_byte;

    always_comb begin
        case (r_class)
            u8sv_pkg::RC_E0: begin
                cont_ok = (b >= u8sv_pkg::BYTE_CONT_A0) && (b <= u8sv_pkg::BYTE_CONT_HI);
            end
            u8sv_pkg::RC_ED: begin
                cont_ok = (b >= u8sv_pkg::BYTE_CONT_LO) && (b <= u8sv_pkg::BYTE_CONT_9F);
            end
            u8sv_pkg::RC_F0: begin
                cont_ok = (b >= u8sv_pkg::BYTE_CONT_90) && (b <= u8sv_pkg::BYTE_CONT_HI);
            end
            u8sv_pkg::RC_F4: begin
                cont_ok = (b >= u8sv_pkg::BYTE_CONT_LO) && (b <= u8sv_pkg::BYTE_CONT_8F);
            end
            default: begin
                cont_ok = (b >= u8sv_pkg::BYTE_CONT_LO) && (b <= u8sv_pkg::BYTE_CONT_HI);
            end
        endcase
    end

    always_comb begin
        lead_ok  = 1'b1;
        lead_cnt = 2'd0;
        lead_cls = u8sv_pkg::RC_PLAIN;
        if (b == u8sv_pkg::BYTE_TAB || b == u8sv_pkg::BYTE_LF || b == u8sv_pkg::BYTE_CR
            || (b >= u8sv_pkg::BYTE_PRINT_LO && b <= u8sv_pkg::BYTE_PRINT_HI)) begin
            lead_cnt = 2'd0;
        end else if (b >= u8sv_pkg::BYTE_LEAD2_LO && b <= u8sv_pkg::BYTE_LEAD2_HI) begin
            lead_cnt = 2'd1;
        end else if (b == u8sv_pkg::BYTE_LEAD_E0) begin
            lead_cnt = 2'd2;
            lead_cls = u8sv_pkg::RC_E0;
        end else if (b == u8sv_pkg::BYTE_LEAD_ED) begin
            lead_cnt = 2'd2;
            lead_cls = u8sv_pkg::RC_ED;
        end else if (b > u8sv_pkg::BYTE_LEAD_E0 && b <= u8sv_pkg::BYTE_LEAD3_HI) begin
            lead_cnt = 2'd2;
        end else if (b == u8sv_pkg::BYTE_LEAD_F0) begin
            lead_cnt = 2'd3;
            lead_cls = u8sv_pkg::RC_F0;
        end else if (b > u8sv_pkg::BYTE_LEAD_F0 && b < u8sv_pkg::BYTE_LEAD_F4) begin
            lead_cnt = 2'd3;
        end else if (b == u8sv_pkg::BYTE_LEAD_F4) begin
            lead_cnt = 2'd3;
            lead_cls = u8sv_pkg::RC_F4;
        end else begin
            lead_ok = 1'b0;
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_class   = r_class;
        ok        = 1'b0;
        if (r_error) begin
            ok = 1'b0;
        end else if (r_pending != 2'd0) begin
            if (cont_ok) begin
                n_pending = r_pending - 2'd1;
                n_class   = u8sv_pkg::RC_PLAIN;
                ok        = 1'b1;
            end
        end else if (lead_ok) begin
            n_pending = lead_cnt;
            n_class   = lead_cls;
            ok        = 1'b1;
        end
        n_error = r_error | ~ok;

        o_item.byte_ok       = ok;
        o_item.string_valid  = i_item.final_byte && ok && (n_pending == 2'd0);
        o_item.end_of_string = i_item.final_byte;

        // The last byte of a string always returns the state to idle.
        if (i_item.final_byte) begin
            n_pending = 2'd0;
            n_class   = u8sv_pkg::RC_PLAIN;
            n_error   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_class   <= u8sv_pkg::RC_PLAIN;
            r_error   <= 1'b0;
        end else if (i_en) begin
            r_pending <= n_pending;
            r_class   <= n_class;
            r_error   <= n_error;
        end
    end

    `U8SV_ASSERT_NOW(a_idle_class_plain, i_clk, i_rst_n, r_pending == 2'd0, r_class == u8sv_pkg::RC_PLAIN)
    `U8SV_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, i_en && r_error && !i_item.final_byte, r_error)
    `U8SV_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, i_en && i_item.final_byte, r_pending == 2'd0 && !r_error)
    `U8SV_ASSERT_NOW(a_valid_implies_ok, i_clk, i_rst_n, o_item.string_valid, o_item.byte_ok && o_item.end_of_string)

endmodule

// ===== hw/rtl/utf8_stream_validator.sv =====
// Flow: a byte accepted into the input register is judged by the step unit and then offered
// from the result register. Throughput: one byte per clock cycle while the output is not stalled;
// while a result waits, one more byte can enter the input register before the input stalls.
// Reset: synchronous, active low; clears both stage valid flags and the decode state.
// ----------------------------------------------------------------------------
// UTF-8 stream validator
// Strict UTF-8 checker with an input register, a step unit and a result register.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  u8sv_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u8sv_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    u8sv_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    u8sv_pkg::t_out_item r_out_item;

    logic                out_free;
    logic                advance;
    logic                in_accept;
    u8sv_pkg::t_out_item step_item;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    u8sv_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in_item),
        .o_item  (step_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
